// ----- rtl/duplicate_message_filter_macros.svh -----
// assertion macros for the duplicate message filter
`ifndef DUPLICATE_MESSAGE_FILTER_MACROS_SVH
`define DUPLICATE_MESSAGE_FILTER_MACROS_SVH

// same-cycle implication, sampled on clk, off while in reset
`define DMF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define DMF_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/dmf_pkg.sv -----
// shared constants and types for the duplicate message filter
`default_nettype none

package dmf_pkg;

    localparam int NUM_SLOTS = 12;
    localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int ADDR_W    = 48;
    localparam int SEQ_W     = 8;
    localparam int TIME_W    = 32;

    localparam logic [TIME_W-1:0] DEFAULT_WINDOW_MS = TIME_W'(5000);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_COMMIT
    } dmf_state_t;

    typedef struct packed {
        logic              capture;
        logic              rd_en;
        logic [SLOT_W-1:0] rd_idx;
        logic              commit;
    } dmf_cmd_t;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [SEQ_W-1:0]  seq;
        logic [TIME_W-1:0] tstamp;
    } dmf_entry_t;

endpackage

`default_nettype wire

// ----- rtl/duplicate_message_filter.sv -----
// top level of the duplicate message filter
`default_nettype none
`include "duplicate_message_filter_macros.svh"

// A request is taken when start is high and busy is low. The block then
// reads its NUM_SLOTS cache slots one per cycle from a slot memory with a
// single read port, evaluates the last read in ST_DRAIN and writes back in
// ST_COMMIT, and only then returns to idle, where it can accept the next
// request; the single memory read port sets this pace.
// The result appears on is_duplicate with done high for exactly one cycle,
// in the cycle when busy drops; the receiver cannot stall it, so it must
// take it then. A new request may be started in that same cycle. The
// window register is written through cfg_valid/cfg_data (cfg_ready is
// always high) and must only be written while busy is low.

module duplicate_message_filter (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [dmf_pkg::ADDR_W-1:0]   sender_address,
    input  wire logic [dmf_pkg::SEQ_W-1:0]    sequence_number,
    input  wire logic [dmf_pkg::TIME_W-1:0]   now_ms,
    output logic                              done,
    output logic                              is_duplicate,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [dmf_pkg::TIME_W-1:0]   cfg_data
);
    import dmf_pkg::*;

    dmf_cmd_t cmd;

    assign cfg_ready = 1'b1;

    dmf_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd)
    );

    dmf_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .cfg_valid       (cfg_valid),
        .cfg_data        (cfg_data),
        .sender_address  (sender_address),
        .sequence_number (sequence_number),
        .now_ms          (now_ms),
        .done            (done),
        .is_duplicate    (is_duplicate)
    );

    `DMF_ASSERT_NOW(a_done_when_idle, done, !busy, "result strobe while busy")
    `DMF_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted request did not start")
    `DMF_ASSERT_NXT(a_commit_done, cmd.commit, done, "write-back without result strobe")

endmodule

`default_nettype wire

// ----- rtl/dmf_ctrl.sv -----
// controller: sequences the slot scan and the write-back of one request
`default_nettype none

module dmf_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    output dmf_pkg::dmf_cmd_t      cmd
);
    import dmf_pkg::*;

    dmf_state_t        state_reg;
    dmf_state_t        state_next;
    logic [SLOT_W-1:0] cnt_reg;
    logic [SLOT_W-1:0] cnt_next;
    logic              last_slot;

    assign last_slot = (cnt_reg == SLOT_W'(NUM_SLOTS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (last_slot)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:  state_next = ST_COMMIT;
            ST_COMMIT: state_next = ST_IDLE;
        endcase
    end

    // slot counter
    always_comb
    begin
        if (state_reg == ST_SCAN)
            cnt_next = cnt_reg + SLOT_W'(1);
        else
            cnt_next = '0;
    end

    // outputs
    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy        = 1'b0;
                cmd.capture = start;
            end
            ST_SCAN:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_idx = cnt_reg;
            end
            ST_DRAIN:  cmd.rd_en = 1'b0;
            ST_COMMIT: cmd.commit = 1'b1;
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/dmf_datapath.sv -----
// datapath: slot memory, valid bits, match and eviction tracking, result register
`default_nettype none

module dmf_datapath (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire dmf_pkg::dmf_cmd_t            cmd,
    input  wire logic                         cfg_valid,
    input  wire logic [dmf_pkg::TIME_W-1:0]   cfg_data,
    input  wire logic [dmf_pkg::ADDR_W-1:0]   sender_address,
    input  wire logic [dmf_pkg::SEQ_W-1:0]    sequence_number,
    input  wire logic [dmf_pkg::TIME_W-1:0]   now_ms,
    output logic                              done,
    output logic                              is_duplicate
);
    import dmf_pkg::*;

    dmf_entry_t           slot_mem_reg [NUM_SLOTS];
    dmf_entry_t           rd_data_reg;
    logic [SLOT_W-1:0]    rd_idx_reg;
    logic                 rd_vld_reg;

    logic [NUM_SLOTS-1:0] valid_reg;
    logic [NUM_SLOTS-1:0] valid_next;
    logic [TIME_W-1:0]    window_reg;

    logic [ADDR_W-1:0]    addr_in_reg;
    logic [SEQ_W-1:0]     seq_in_reg;
    logic [TIME_W-1:0]    now_in_reg;

    logic                 hit_reg,       hit_next;
    logic                 dup_reg,       dup_next;
    logic [SLOT_W-1:0]    hit_idx_reg,   hit_idx_next;
    logic                 free_reg,      free_next;
    logic [SLOT_W-1:0]    free_idx_reg,  free_idx_next;
    logic                 best_set_reg,  best_set_next;
    logic [SLOT_W-1:0]    best_idx_reg,  best_idx_next;
    logic [TIME_W-1:0]    best_age_reg,  best_age_next;
    logic                 done_reg,      done_next;
    logic                 dup_out_reg,   dup_out_next;

    logic                 eval_valid;
    logic                 eval_hit;
    logic                 eval_dup;
    logic [TIME_W-1:0]    eval_age;
    logic                 wr_en;
    logic [SLOT_W-1:0]    wr_idx;
    dmf_entry_t           wr_data;

    // slot memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
            slot_mem_reg[wr_idx] <= wr_data;
        if (cmd.rd_en)
            rd_data_reg <= slot_mem_reg[cmd.rd_idx];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            addr_in_reg <= sender_address;
            seq_in_reg  <= sequence_number;
            now_in_reg  <= now_ms;
        end
        rd_idx_reg    <= cmd.rd_idx;
        hit_idx_reg   <= hit_idx_next;
        dup_reg       <= dup_next;
        free_idx_reg  <= free_idx_next;
        best_idx_reg  <= best_idx_next;
        best_age_reg  <= best_age_next;
        dup_out_reg   <= dup_out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg   <= DEFAULT_WINDOW_MS;
            valid_reg    <= '0;
            rd_vld_reg   <= 1'b0;
            hit_reg      <= 1'b0;
            free_reg     <= 1'b0;
            best_set_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                window_reg <= cfg_data;
            valid_reg    <= valid_next;
            rd_vld_reg   <= cmd.rd_en;
            hit_reg      <= hit_next;
            free_reg     <= free_next;
            best_set_reg <= best_set_next;
            done_reg     <= done_next;
        end
    end

    // evaluate the slot read in the previous cycle
    always_comb
    begin
        eval_valid = valid_reg[rd_idx_reg];
        eval_age   = now_in_reg - rd_data_reg.tstamp;
        eval_hit   = eval_valid && (rd_data_reg.addr == addr_in_reg);
        eval_dup   = (rd_data_reg.seq == seq_in_reg) && (eval_age < window_reg);

        hit_next      = hit_reg;
        dup_next      = dup_reg;
        hit_idx_next  = hit_idx_reg;
        free_next     = free_reg;
        free_idx_next = free_idx_reg;
        best_set_next = best_set_reg;
        best_idx_next = best_idx_reg;
        best_age_next = best_age_reg;

        if (cmd.capture)
        begin
            hit_next      = 1'b0;
            free_next     = 1'b0;
            best_set_next = 1'b0;
        end
        else if (rd_vld_reg)
        begin
            if (eval_hit && !hit_reg)
            begin
                hit_next     = 1'b1;
                hit_idx_next = rd_idx_reg;
                dup_next     = eval_dup;
            end
            if (!eval_valid && !free_reg)
            begin
                free_next     = 1'b1;
                free_idx_next = rd_idx_reg;
            end
            // oldest slot, first index wins on equal age
            if (eval_valid && (!best_set_reg || (eval_age > best_age_reg)))
            begin
                best_set_next = 1'b1;
                best_idx_next = rd_idx_reg;
                best_age_next = eval_age;
            end
        end
    end

    // write-back and result
    always_comb
    begin
        wr_en   = cmd.commit && !(hit_reg && dup_reg);
        wr_data = '{addr: addr_in_reg, seq: seq_in_reg, tstamp: now_in_reg};
        if (hit_reg)
            wr_idx = hit_idx_reg;
        else if (free_reg)
            wr_idx = free_idx_reg;
        else
            wr_idx = best_idx_reg;

        valid_next = valid_reg;
        if (wr_en)
            valid_next[wr_idx] = 1'b1;

        done_next    = cmd.commit;
        dup_out_next = dup_out_reg;
        if (cmd.commit)
            dup_out_next = hit_reg && dup_reg;
    end

    assign done         = done_reg;
    assign is_duplicate = dup_out_reg;

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// self-checking testbench for the duplicate message filter
module tb;
    import dmf_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 20;
    localparam int POOL_SIZE      = 16;
    localparam int PHASE_ITEMS    = 225;

    logic                clk;
    logic                rst_n           = 1'b0;
    logic                start           = 1'b0;
    logic [ADDR_W-1:0]   sender_address  = '0;
    logic [SEQ_W-1:0]    sequence_number = '0;
    logic [TIME_W-1:0]   now_ms          = '0;
    logic                cfg_valid       = 1'b0;
    logic [TIME_W-1:0]   cfg_data        = '0;
    logic                busy;
    logic                done;
    logic                is_duplicate;
    logic                cfg_ready;

    // predicted cache contents and window
    logic [ADDR_W-1:0]   cache_addr [NUM_SLOTS];
    logic [SEQ_W-1:0]    cache_seq  [NUM_SLOTS];
    logic [TIME_W-1:0]   cache_time [NUM_SLOTS];
    bit                  cache_valid [NUM_SLOTS];
    logic [TIME_W-1:0]   window_ms = DEFAULT_WINDOW_MS;

    bit                  dup_expected [$];
    logic [TIME_W-1:0]   clock_ms;
    logic [ADDR_W-1:0]   addr_pool [POOL_SIZE];
    logic [SEQ_W-1:0]    pool_seq  [POOL_SIZE];

    int                  errors          = 0;
    int                  requests_sent   = 0;
    int                  results_checked = 0;
    int                  dups_seen       = 0;
    int                  window_writes   = 0;

    duplicate_message_filter DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .sender_address  (sender_address),
        .sequence_number (sequence_number),
        .now_ms          (now_ms),
        .done            (done),
        .is_duplicate    (is_duplicate),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            cache_valid[i] = 1'b0;
            cache_addr[i]  = '0;
            cache_seq[i]   = '0;
            cache_time[i]  = '0;
        end
    end

    function automatic bit filter_message(input logic [ADDR_W-1:0] addr,
                                          input logic [SEQ_W-1:0]  seq,
                                          input logic [TIME_W-1:0] now);
        int                victim;
        bit                found;
        logic [TIME_W-1:0] age;
        logic [TIME_W-1:0] victim_age;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            if (cache_valid[i] && cache_addr[i] == addr)
            begin
                age = now - cache_time[i];
                if (cache_seq[i] == seq && age < window_ms)
                    return 1'b1;
                cache_seq[i]  = seq;
                cache_time[i] = now;
                return 1'b0;
            end
        end
        victim = 0;
        found  = 1'b0;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            if (!found)
            begin
                if (!cache_valid[i])
                begin
                    victim = i;
                    found  = 1'b1;
                end
                else
                begin
                    age        = now - cache_time[i];
                    victim_age = now - cache_time[victim];
                    if (age > victim_age)
                        victim = i;
                end
            end
        end
        cache_addr[victim]  = addr;
        cache_seq[victim]   = seq;
        cache_time[victim]  = now;
        cache_valid[victim] = 1'b1;
        return 1'b0;
    endfunction

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (dup_expected.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual is_duplicate=%0b",
                         $time, is_duplicate);
                errors++;
            end
            else
            begin
                bit want;
                want = dup_expected.pop_front();
                results_checked++;
                if (is_duplicate)
                    dups_seen++;
                if (is_duplicate !== want)
                begin
                    $display("%0t: is_duplicate mismatch, expected %0b, actual %0b",
                             $time, want, is_duplicate);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((start && !busy) || done || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t: watchdog expired, %0d results outstanding", $time, dup_expected.size());
        $display("simulation failed");
        $finish;
    end

    task automatic send_request(input logic [ADDR_W-1:0] addr,
                                input logic [SEQ_W-1:0]  seq,
                                input logic [TIME_W-1:0] now);
        start           <= 1'b1;
        sender_address  <= addr;
        sequence_number <= seq;
        now_ms          <= now;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        dup_expected.push_back(filter_message(addr, seq, now));
        requests_sent++;
    endtask

    task automatic sender_gap(input int idle_pct);
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge clk);
        end
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (dup_expected.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_window(input logic [TIME_W-1:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        window_ms = value;
        window_writes++;
    endtask

    task automatic test_default_window();
        send_request(48'h0000_1111_2222, 8'd0, 32'd1000);
        send_request(48'h0000_1111_2222, 8'd0, 32'd5999);
        send_request(48'h0000_1111_2222, 8'd0, 32'd6000);
        send_request(48'h0000_1111_2222, 8'd1, 32'd6001);
    endtask

    task automatic test_field_extremes();
        send_request('1, 8'hFF, 32'hFFFF_FFFF);
        send_request('1, 8'hFF, 32'h0000_0000);
        send_request('0, 8'h00, 32'h0000_0000);
        // time far ahead of the stored one gives a huge age
        send_request('0, 8'h00, 32'hFFFF_FFF0);
        send_request('0, 8'h00, 32'hFFFF_FFF1);
    endtask

    task automatic test_window_limits();
        set_window(32'd0);
        send_request(48'hA5A5_5A5A_0F0F, 8'd7, 32'd20000);
        send_request(48'hA5A5_5A5A_0F0F, 8'd7, 32'd20000);
        set_window(32'hFFFF_FFFF);
        send_request(48'hA5A5_5A5A_0F0F, 8'd7, 32'd20010);
    endtask

    task automatic test_full_cache_eviction();
        set_window(DEFAULT_WINDOW_MS);
        // first half share one timestamp so the oldest age ties
        for (int i = 0; i < NUM_SLOTS; i++)
            send_request(48'h0C0C_0000_0000 + i, 8'(i), (i < 6) ? 32'd100000 : 32'd100000 + i);
        send_request(48'h0D0D_0000_0001, 8'd3, 32'd100020);
        send_request(48'h0C0C_0000_0000, 8'd0, 32'd100021);
    endtask

    task automatic test_random_traffic(input logic [TIME_W-1:0] window, input int idle_pct);
        int                k;
        int                r;
        logic [ADDR_W-1:0] addr;
        logic [SEQ_W-1:0]  seq;
        set_window(window);
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            addr_pool[i] = ADDR_W'({$urandom, $urandom});
            pool_seq[i]  = 8'($urandom);
        end
        clock_ms = $urandom;
        for (int n = 0; n < PHASE_ITEMS; n++)
        begin
            r = $urandom_range(99);
            if (r < 4)
                clock_ms = $urandom;
            else if (r < 10)
                clock_ms = clock_ms + $urandom_range(1000, 20000);
            else
                clock_ms = clock_ms + $urandom_range(0, 400);
            if ($urandom_range(99) < 85)
            begin
                k = $urandom_range(POOL_SIZE - 1);
                r = $urandom_range(99);
                if (r < 50)
                    seq = pool_seq[k];
                else if (r < 80)
                    seq = pool_seq[k] + 8'd1;
                else
                    seq = 8'($urandom);
                pool_seq[k] = seq;
                addr = addr_pool[k];
            end
            else
            begin
                addr = ADDR_W'({$urandom, $urandom});
                seq  = 8'($urandom);
            end
            send_request(addr, seq, clock_ms);
            sender_gap(idle_pct);
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_window();
        test_field_extremes();
        test_window_limits();
        test_full_cache_eviction();

        test_random_traffic(DEFAULT_WINDOW_MS, 0);
        test_random_traffic(32'd0, 62);
        test_random_traffic(32'hFFFF_FFFF, 34);
        test_random_traffic(32'd1, 0);
        test_random_traffic($urandom, 62);
        test_random_traffic(32'd700, 34);

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (dup_expected.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time, dup_expected.size());
            errors++;
        end

        $display("sent %0d requests (%0d flagged duplicate) across %0d window writes",
                 requests_sent, dups_seen, window_writes);
        $display("compared %0d results, %0d errors", results_checked, errors);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
